// File: rtl/rcl_pkg.sv
// shared constants, types and the cube root step function for the rgb to cielab converter
`default_nettype none
package rcl_pkg;

    localparam int NUM_CH = 3;
    localparam int IN_W = 16;
    localparam int WORK_BITS = 20;
    localparam int OUT_SHIFT = WORK_BITS - 8;

    localparam logic [IN_W-1:0] IN_ONE = 16'd32768;

    // rgb to xyz matrix scaled by 10^6, row per output channel
    localparam logic [19:0] COEF [NUM_CH][NUM_CH] = '{
        '{20'd412453, 20'd357580, 20'd180423},
        '{20'd212671, 20'd715160, 20'd72169},
        '{20'd19334,  20'd119193, 20'd950227}
    };
    localparam logic [20:0] DEN [NUM_CH] = '{21'd950456, 21'd1000000, 21'd1088754};
    localparam logic [20:0] HALF_DEN [NUM_CH] = '{21'd475228, 21'd500000, 21'd544377};
    // floor(2^41 / den), applied to the numerator without its low 9 bits
    localparam logic [21:0] DEN_RECIP [NUM_CH] = '{22'd2313650, 22'd2199023, 22'd2019761};

    // t * 10^6 > 8856 * 2^20 reduces to t > 9286
    localparam logic [20:0] KNEE_Q = 21'd9286;

    localparam logic [12:0] LIN_MUL = 13'd7787;
    localparam logic [8:0]  LIN_ADD = 9'd500;
    localparam logic [27:0] RECIP_1000 = 28'd137438954;
    localparam int          SH_1000 = 37;
    localparam logic [18:0] F_OFS = 19'd144631;

    localparam logic [13:0] L_MUL = 14'd9033;
    localparam logic [2:0]  L_ADD = 3'd5;
    localparam logic [27:0] RECIP_10 = 28'd214748365;
    localparam int          SH_10 = 31;

    localparam logic [31:0] L_OFS = 32'd16777216;
    localparam logic [14:0] L_MAX = 15'd25600;

    localparam int DIV_STEPS = 3;
    localparam int ROOT_STEPS = 21;

    typedef struct packed {
        logic [60:0] rem;
        logic [20:0] r;
        logic [41:0] r2;
    } t_root;

    // one cube root digit; rem holds n - r^3, r2 holds r^2
    function automatic t_root root_step(input t_root s, input int b);
        t_root       res;
        logic [63:0] t;
        t = (64'(s.r2) << (b + 1)) + (64'(s.r2) << b)
          + (64'(s.r) << (2 * b + 1)) + (64'(s.r) << (2 * b))
          + (64'd1 << (3 * b));
        res = s;
        if (t <= 64'(s.rem)) begin
            res.rem = s.rem - 61'(t);
            res.r2 = s.r2 + 42'(64'(s.r) << (b + 1)) + 42'(64'd1 << (2 * b));
            res.r = s.r | 21'(64'd1 << b);
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// File: rtl/rgb_to_cielab_pixel_unit.sv
// rgb to cielab d65 pixel converter, fully pipelined
//
// usage: drive i_red, i_green, i_blue (unsigned q1.15, clamped to 1.0) and
// i_last_in with start high; the request is taken at that clock edge since
// busy is always low. one pixel may be sent every clock cycle.
// the result appears on o_lightness (unsigned q8), o_green_red and
// o_blue_yellow (signed q8) and o_last_out, marked by o_strobe for exactly
// one cycle. results leave in request order, one per request.
// the pipeline is 33 register stages: clamp, product and sum stages, a
// 3-stage reciprocal divider per xyz channel (estimate, back-multiply,
// fix-up), the linear-branch reciprocal multiplies and root seed, a
// 21-stage digit-by-digit cube root per channel, then root rounding, the
// lab arithmetic and output saturation. throughput is one pixel per cycle.
// reset (synchronous, active low) clears the valid bits only; pixels in
// flight are dropped. the receiver cannot stall, so no back pressure exists.
`default_nettype none
module rgb_to_cielab_pixel_unit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [15:0]         i_red,
    input  wire logic [15:0]         i_green,
    input  wire logic [15:0]         i_blue,
    input  wire logic                i_last_in,
    output logic                     o_strobe,
    output logic [14:0]              o_lightness,
    output logic signed [15:0]       o_green_red,
    output logic signed [15:0]       o_blue_yellow,
    output logic                     o_last_out
);

    localparam int ST_DIV = 3;
    localparam int ST_F0 = ST_DIV + rcl_pkg::DIV_STEPS;
    localparam int ST_ROOT = ST_F0 + 3;
    localparam int ST_RND = ST_ROOT + rcl_pkg::ROOT_STEPS;
    localparam int NSTG = ST_RND + 3;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] r_lst;
    logic            accept;

    logic [15:0]       r_ch0 [rcl_pkg::NUM_CH];
    logic [35:0]       r_prod1 [rcl_pkg::NUM_CH][rcl_pkg::NUM_CH];
    logic [40:0]       r_num2 [rcl_pkg::NUM_CH];
    logic [52:0]       r_dp [rcl_pkg::NUM_CH];
    logic [40:0]       r_dn1 [rcl_pkg::NUM_CH];
    logic [20:0]       r_dq [rcl_pkg::NUM_CH];
    logic [41:0]       r_dm [rcl_pkg::NUM_CH];
    logic [40:0]       r_dn2 [rcl_pkg::NUM_CH];
    logic [20:0]       r_quo [rcl_pkg::NUM_CH];
    logic [20:0]       r_f0q [rcl_pkg::NUM_CH];
    logic [26:0]       r_f0ln [rcl_pkg::NUM_CH];
    logic [27:0]       r_f0lt;
    logic [20:0]       r_f1q [rcl_pkg::NUM_CH];
    logic [54:0]       r_f1p [rcl_pkg::NUM_CH];
    logic [55:0]       r_f1lp;
    rcl_pkg::t_root    r_root [rcl_pkg::ROOT_STEPS+1][rcl_pkg::NUM_CH];
    logic [18:0]       r_clin [rcl_pkg::ROOT_STEPS+1][rcl_pkg::NUM_CH];
    logic              r_cab [rcl_pkg::ROOT_STEPS+1][rcl_pkg::NUM_CH];
    logic [23:0]       r_clt [rcl_pkg::ROOT_STEPS+1];
    logic [20:0]       r_fv [rcl_pkg::NUM_CH];
    logic              r_fab;
    logic [23:0]       r_flt;
    logic signed [31:0] r_e0l;
    logic signed [31:0] r_e0a;
    logic signed [31:0] r_e0b;
    logic [14:0]       r_lgt;
    logic signed [15:0] r_gr;
    logic signed [15:0] r_by;

    logic [15:0]       raw [rcl_pkg::NUM_CH];
    logic signed [31:0] n_ls;
    logic signed [31:0] n_as;
    logic signed [31:0] n_bs;

    assign busy = 1'b0;
    assign accept = start & ~busy;
    assign raw[0] = i_red;
    assign raw[1] = i_green;
    assign raw[2] = i_blue;

    // valid and last bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], accept};
        end
    end

    always_ff @(posedge i_clk) begin
        r_lst <= {r_lst[NSTG-2:0], i_last_in};
    end

    // clamp, matrix products, sums with rounding offset
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < rcl_pkg::NUM_CH; c++) begin
            r_ch0[c] <= (raw[c] > rcl_pkg::IN_ONE) ? rcl_pkg::IN_ONE : raw[c];
            for (int k = 0; k < rcl_pkg::NUM_CH; k++) begin
                r_prod1[c][k] <= 36'(rcl_pkg::COEF[c][k]) * 36'(r_ch0[k]);
            end
            r_num2[c] <= (41'(r_prod1[c][0] + r_prod1[c][1] + r_prod1[c][2]) << 5)
                       + 41'(rcl_pkg::HALF_DEN[c]);
        end
    end

    // divide by the white point: reciprocal estimate, back-multiply, fix-up
    // the estimate is never above the quotient and at most two below it
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < rcl_pkg::NUM_CH; c++) begin
            logic [41:0] rem;
            r_dp[c] <= 53'(r_num2[c][40:9]) * 53'(rcl_pkg::DEN_RECIP[c]);
            r_dn1[c] <= r_num2[c];
            r_dq[c] <= r_dp[c][52:32];
            r_dm[c] <= 42'(r_dp[c][52:32]) * 42'(rcl_pkg::DEN[c]);
            r_dn2[c] <= r_dn1[c];
            rem = 42'(r_dn2[c]) - r_dm[c];
            if (rem >= {20'd0, rcl_pkg::DEN[c], 1'b0}) begin
                r_quo[c] <= r_dq[c] + 21'd2;
            end else if (rem >= 42'(rcl_pkg::DEN[c])) begin
                r_quo[c] <= r_dq[c] + 21'd1;
            end else begin
                r_quo[c] <= r_dq[c];
            end
        end
    end

    // linear branch: numerators, reciprocal multiplies, then root seed
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < rcl_pkg::NUM_CH; c++) begin
            r_f0q[c] <= r_quo[c];
            r_f0ln[c] <= 27'(rcl_pkg::LIN_MUL) * 27'(r_quo[c][13:0])
                       + 27'(rcl_pkg::LIN_ADD);
            r_f1q[c] <= r_f0q[c];
            r_f1p[c] <= 55'(r_f0ln[c]) * 55'(rcl_pkg::RECIP_1000);
            r_clin[0][c] <= 19'(r_f1p[c] >> rcl_pkg::SH_1000) + rcl_pkg::F_OFS;
            r_cab[0][c] <= r_f1q[c] > rcl_pkg::KNEE_Q;
            r_root[0][c] <= '{rem: 61'(r_f1q[c]) << 40, r: '0, r2: '0};
        end
        r_f0lt <= 28'(rcl_pkg::L_MUL) * 28'(r_quo[1][13:0])
                + 28'(rcl_pkg::L_ADD);
        r_f1lp <= 56'(r_f0lt) * 56'(rcl_pkg::RECIP_10);
        r_clt[0] <= 24'(r_f1lp >> rcl_pkg::SH_10);
    end

    // cube root pipeline, bit 20 down to bit 0
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < rcl_pkg::ROOT_STEPS; i++) begin
            for (int c = 0; c < rcl_pkg::NUM_CH; c++) begin
                r_root[i+1][c] <= rcl_pkg::root_step(r_root[i][c], rcl_pkg::ROOT_STEPS - 1 - i);
                r_clin[i+1][c] <= r_clin[i][c];
                r_cab[i+1][c] <= r_cab[i][c];
            end
            r_clt[i+1] <= r_clt[i];
        end
    end

    // round root to nearest: 12r^2 + 6r + 1 <= 8(n - r^3), then pick the branch
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < rcl_pkg::NUM_CH; c++) begin
            logic [63:0]    lhs;
            rcl_pkg::t_root s;
            s = r_root[rcl_pkg::ROOT_STEPS][c];
            lhs = (64'(s.r2) << 3) + (64'(s.r2) << 2) + (64'(s.r) << 2)
                + (64'(s.r) << 1) + 64'd1;
            if (r_cab[rcl_pkg::ROOT_STEPS][c]) begin
                r_fv[c] <= s.r + 21'((lhs <= (64'(s.rem) << 3)) ? 1 : 0);
            end else begin
                r_fv[c] <= 21'(r_clin[rcl_pkg::ROOT_STEPS][c]);
            end
        end
        r_fab <= r_cab[rcl_pkg::ROOT_STEPS][1];
        r_flt <= r_clt[rcl_pkg::ROOT_STEPS];
    end

    // lab arithmetic in q20
    always_ff @(posedge i_clk) begin
        if (r_fab) begin
            r_e0l <= $signed(32'(r_fv[1]) * 32'd116 - rcl_pkg::L_OFS);
        end else begin
            r_e0l <= $signed(32'(r_flt));
        end
        r_e0a <= ($signed(32'(r_fv[0])) - $signed(32'(r_fv[1]))) * 32'sd500;
        r_e0b <= ($signed(32'(r_fv[1])) - $signed(32'(r_fv[2]))) * 32'sd200;
    end

    // round half up by arithmetic shift, then saturate
    always_comb begin
        n_ls = (r_e0l + 32'sd2048) >>> rcl_pkg::OUT_SHIFT;
        n_as = (r_e0a + 32'sd2048) >>> rcl_pkg::OUT_SHIFT;
        n_bs = (r_e0b + 32'sd2048) >>> rcl_pkg::OUT_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (n_ls < 32'sd0) begin
            r_lgt <= '0;
        end else if (n_ls > $signed(32'(rcl_pkg::L_MAX))) begin
            r_lgt <= rcl_pkg::L_MAX;
        end else begin
            r_lgt <= n_ls[14:0];
        end
        if (n_as < -32'sd32768) begin
            r_gr <= -16'sd32768;
        end else if (n_as > 32'sd32767) begin
            r_gr <= 16'sd32767;
        end else begin
            r_gr <= n_as[15:0];
        end
        if (n_bs < -32'sd32768) begin
            r_by <= -16'sd32768;
        end else if (n_bs > 32'sd32767) begin
            r_by <= 16'sd32767;
        end else begin
            r_by <= n_bs[15:0];
        end
    end

    assign o_strobe = r_vld[NSTG-1];
    assign o_last_out = r_lst[NSTG-1];
    assign o_lightness = r_lgt;
    assign o_green_red = r_gr;
    assign o_blue_yellow = r_by;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##NSTG o_strobe)
        else $error("request did not come out after the pipeline latency");

    a_light_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_lightness <= rcl_pkg::L_MAX)
        else $error("lightness above 100");

    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_RND] |-> r_fv[1] <= 21'(1 << rcl_pkg::WORK_BITS))
        else $error("normalized y above one");

    a_div_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ST_F0] |-> r_f0q[1] <= 21'(1 << rcl_pkg::WORK_BITS))
        else $error("divider quotient above one");

endmodule
`default_nettype wire
